// ----- hw/rtl/avd_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// avd_pkg: shared types and constants of the ADPCM voice decoder
// Command and format codes, register indexes, and the control/status bundles
// that pass between the controller and the datapath.
// -----------------------------------------------------------------------------
package avd_pkg;

	localparam int DATA_W   = 16;
	localparam int SAMPLE_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 64;

	localparam int PROD_W   = 32;
	localparam int ACC_W    = 34;
	localparam int VAL_W    = 25;
	localparam int PRED_SHIFT = 11;
	localparam logic [ACC_W-1:0] PRED_ROUND = ACC_W'(32'h400);

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

	// Command carried in tuser of the input stream
	typedef enum logic [1:0] {
		CMD_DATA   = 2'd0,
		CMD_HEADER = 2'd1,
		CMD_LOOP   = 2'd2,
		CMD_START  = 2'd3
	} cmd_code_t;

	// Sample formats
	localparam logic [1:0] FMT_ADPCM = 2'd0;
	localparam logic [1:0] FMT_PCM16 = 2'd1;
	localparam logic [1:0] FMT_PCM8  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_C    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_D    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_HIST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_CTX  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STREAMING = 3'd7;

	// Controller -> datapath commands
	typedef struct packed {
		logic capture;     // latch the data word
		logic load_hdr;    // scale/index from the header byte
		logic load_loop;   // loop-back reload
		logic load_start;  // initial history
		logic mul0;        // c0 * newest
		logic mul1;        // c1 * older, start the sum
		logic emit_adpcm;  // finish one nibble and write the output
		logic emit_pcm;    // write a PCM sample
		logic nib_lo;      // working on the low nibble
	} ctrl_t;

	// Datapath -> controller status
	typedef struct packed {
		logic [1:0] fmt;
		logic       out_free;
	} stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/adpcm_voice_decoder.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// adpcm_voice_decoder: one-voice ADPCM / PCM16 / PCM8 sample decoder
// Turns a stream of command words into signed 16-bit samples.
// -----------------------------------------------------------------------------
//  channel  | signals                         | payload
//  ---------+---------------------------------+------------------------------
//  s_axis   | tvalid tready tdata[15:0] tuser | tdata: encoded_data
//           |                                 | tuser: cmd
//  m_axis   | tvalid tready tdata[15:0] tlast | tdata: sample, tlast: last
//  cfg      | valid ready index[2:0] data     | register write, always ready
//
//  An ADPCM data word is accepted, then each nibble takes two passes through the
//  single 16x16 multiplier and a step for the sum, floor shift and clamp. A PCM
//  data word is accepted and then written out; header, loop-back and start words
//  are handled as they are accepted. Reset clears the configuration, the scale
//  byte and the history. A stalled sink holds the decoder in its sum step (for
//  PCM, its PCM step) with the next sample ready; a new word is taken once the
//  last sample of the current word sits in the output register.
// -----------------------------------------------------------------------------
module adpcm_voice_decoder (
	input  wire                             clk,
	input  wire                             arst_n,
	// input words
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire [avd_pkg::DATA_W-1:0]       s_axis_tdata,   // [15:0] encoded_data
	input  wire [1:0]                       s_axis_tuser,   // [1:0] cmd
	// output samples
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	output logic [avd_pkg::SAMPLE_W-1:0]    m_axis_tdata,   // [15:0] sample
	output logic                            m_axis_tlast,
	// configuration writes
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire [avd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [avd_pkg::CFG_W-1:0]        cfg_data
);

	avd_pkg::ctrl_t ctrl;
	avd_pkg::stat_t status;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	// sequence the work: command decode, multiplier passes, output handoff
	avd_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.status        (status),
		.ctrl          (ctrl)
	);

	// hold configuration and voice state, compute and drive the samples
	avd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.ctrl          (ctrl),
		.status        (status)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/avd_ctrl.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// avd_ctrl: sequencing controller of the ADPCM voice decoder
// Decodes the input command and steps the shared multiplier through the two
// predictor products and the final sum of each nibble.
// -----------------------------------------------------------------------------
module avd_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire [1:0]        s_axis_tuser,
	input  wire avd_pkg::stat_t status,
	output avd_pkg::ctrl_t   ctrl
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL0 = 5'b00010,
		ST_MUL1 = 5'b00100,
		ST_SUM  = 5'b01000,
		ST_PCM  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   nib_q, nib_d;
	logic   accept;

	always_comb begin
		state_d = state_q;
		nib_d   = nib_q;
		ctrl    = '0;
		ctrl.nib_lo = nib_q;
		s_axis_tready = (state_q == ST_IDLE);
		accept = s_axis_tvalid && s_axis_tready;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (avd_pkg::cmd_code_t'(s_axis_tuser))
						avd_pkg::CMD_DATA: begin
							ctrl.capture = 1'b1;
							if (status.fmt == avd_pkg::FMT_ADPCM) begin
								nib_d   = 1'b0;
								state_d = ST_MUL0;
							end else begin
								state_d = ST_PCM;
							end
						end
						avd_pkg::CMD_HEADER: ctrl.load_hdr   = 1'b1;
						avd_pkg::CMD_LOOP:   ctrl.load_loop  = 1'b1;
						avd_pkg::CMD_START:  ctrl.load_start = 1'b1;
						default: ;
					endcase
				end
			end
			ST_MUL0: begin
				ctrl.mul0 = 1'b1;
				state_d   = ST_MUL1;
			end
			ST_MUL1: begin
				ctrl.mul1 = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				// hold the sum until the output register frees up
				if (status.out_free) begin
					ctrl.emit_adpcm = 1'b1;
					if (nib_q) begin
						state_d = ST_IDLE;
					end else begin
						nib_d   = 1'b1;
						state_d = ST_MUL0;
					end
				end
			end
			ST_PCM: begin
				if (status.out_free) begin
					ctrl.emit_pcm = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nib_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			nib_q   <= nib_d;
		end
	end

	a_mul_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL0 |=> state_q == ST_MUL1)
		else $error("second product did not follow the first");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit_adpcm || ctrl.emit_pcm) |-> status.out_free)
		else $error("sample written over a word still pending");

	a_high_then_low: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit_adpcm && !nib_q) |=> (state_q == ST_MUL0 && nib_q))
		else $error("low nibble did not follow the high nibble");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL1 || state_q == ST_SUM) |-> !ctrl.capture)
		else $error("data captured while a byte is in flight");

endmodule
`default_nettype wire

// ----- hw/rtl/avd_dp.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// avd_dp: datapath of the ADPCM voice decoder
// Configuration registers, predictor state, one shared 16x16 multiplier,
// prediction sum with floor shift and clamp, and the output register.
// -----------------------------------------------------------------------------
module avd_dp (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_valid,
	input  wire [avd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [avd_pkg::CFG_W-1:0]           cfg_data,
	input  wire [avd_pkg::DATA_W-1:0]          s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	output logic [avd_pkg::SAMPLE_W-1:0]       m_axis_tdata,
	output logic                               m_axis_tlast,
	input  wire avd_pkg::ctrl_t                ctrl,
	output avd_pkg::stat_t                     status
);

	localparam int SW = avd_pkg::SAMPLE_W;

	// configuration
	logic [1:0]                    fmt_q;
	logic [avd_pkg::CFG_W-1:0]     bank_q [4];
	logic [31:0]                   start_q;
	logic [39:0]                   loop_q;
	logic                          stream_q;

	// voice state
	logic [7:0]                    scale_q;
	logic signed [SW-1:0]          hist_new_q;
	logic signed [SW-1:0]          hist_old_q;

	// working registers
	logic [avd_pkg::DATA_W-1:0]    data_q;
	logic signed [avd_pkg::PROD_W-1:0] prod_q;
	logic signed [avd_pkg::ACC_W-1:0]  acc_q;

	logic                          out_valid_q;
	logic [SW-1:0]                 out_sample_q;
	logic                          out_last_q;

	logic [3:0]                    coef_sel;
	logic [avd_pkg::CFG_W-1:0]     coef_bank;
	logic signed [SW-1:0]          coef;
	logic signed [SW-1:0]          hist_op;
	logic signed [avd_pkg::PROD_W-1:0] prod;
	logic signed [avd_pkg::ACC_W-1:0]  sum;
	logic signed [avd_pkg::ACC_W-1:0]  sum_sh;
	logic signed [3:0]             nib;
	logic signed [avd_pkg::VAL_W-1:0]  nib_term;
	logic signed [avd_pkg::VAL_W-1:0]  val;
	logic signed [SW-1:0]          adpcm_s;
	logic signed [SW-1:0]          pcm_s;
	logic signed [SW-1:0]          new_s;
	logic                          emit;

	// coefficient pair from bits 6:4 of the scale byte, odd member on mul1
	assign coef_sel  = {scale_q[6:4], ctrl.mul1};
	assign coef_bank = bank_q[coef_sel[3:2]];
	assign coef      = signed'(coef_bank[{coef_sel[1:0], 4'b0000} +: SW]);
	assign hist_op   = ctrl.mul1 ? hist_old_q : hist_new_q;
	assign prod      = coef * hist_op;

	// floor shift of the wide sum, then scaled nibble, then clamp
	assign sum      = acc_q + avd_pkg::ACC_W'(prod_q);
	assign sum_sh   = sum >>> avd_pkg::PRED_SHIFT;
	assign nib      = signed'(ctrl.nib_lo ? data_q[3:0] : data_q[7:4]);
	assign nib_term = avd_pkg::VAL_W'(nib) <<< scale_q[3:0];
	assign val      = avd_pkg::VAL_W'(sum_sh) + nib_term;

	always_comb begin
		if (val > avd_pkg::VAL_W'(avd_pkg::SAMPLE_MAX)) begin
			adpcm_s = avd_pkg::SAMPLE_MAX;
		end else if (val < avd_pkg::VAL_W'(avd_pkg::SAMPLE_MIN)) begin
			adpcm_s = avd_pkg::SAMPLE_MIN;
		end else begin
			adpcm_s = SW'(val);
		end
	end

	always_comb begin
		case (fmt_q)
			avd_pkg::FMT_PCM16: pcm_s = signed'(data_q);
			avd_pkg::FMT_PCM8:  pcm_s = signed'({data_q[7:0], 8'h00});
			default:            pcm_s = '0;
		endcase
	end

	assign emit  = ctrl.emit_adpcm || ctrl.emit_pcm;
	assign new_s = ctrl.emit_adpcm ? adpcm_s : pcm_s;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= '0;
			bank_q   <= '{default: '0};
			start_q  <= '0;
			loop_q   <= '0;
			stream_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				avd_pkg::REG_FORMAT:     fmt_q     <= cfg_data[1:0];
				avd_pkg::REG_COEF_A:     bank_q[0] <= cfg_data;
				avd_pkg::REG_COEF_B:     bank_q[1] <= cfg_data;
				avd_pkg::REG_COEF_C:     bank_q[2] <= cfg_data;
				avd_pkg::REG_COEF_D:     bank_q[3] <= cfg_data;
				avd_pkg::REG_START_HIST: start_q   <= cfg_data[31:0];
				avd_pkg::REG_LOOP_CTX:   loop_q    <= cfg_data[39:0];
				avd_pkg::REG_STREAMING:  stream_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// scale and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= '0;
			hist_new_q <= '0;
			hist_old_q <= '0;
		end else begin
			if (ctrl.load_hdr) begin
				scale_q <= s_axis_tdata[7:0];
			end
			if (ctrl.load_loop) begin
				scale_q <= loop_q[39:32];
				if (!stream_q) begin
					hist_new_q <= signed'(loop_q[31:16]);
					hist_old_q <= signed'(loop_q[15:0]);
				end
			end
			if (ctrl.load_start) begin
				hist_new_q <= signed'(start_q[31:16]);
				hist_old_q <= signed'(start_q[15:0]);
			end
			if (emit) begin
				hist_old_q <= hist_new_q;
				hist_new_q <= new_s;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			data_q <= s_axis_tdata;
		end
		if (ctrl.mul0) begin
			prod_q <= prod;
		end
		if (ctrl.mul1) begin
			prod_q <= prod;
			acc_q  <= avd_pkg::ACC_W'(prod_q) + signed'(avd_pkg::PRED_ROUND);
		end
		if (emit) begin
			out_sample_q <= new_s;
			out_last_q   <= ctrl.emit_pcm || ctrl.nib_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_sample_q;
	assign m_axis_tlast    = out_last_q;
	assign status.fmt      = fmt_q;
	assign status.out_free = !out_valid_q || m_axis_tready;

endmodule
`default_nettype wire
